FILE: rtl/csrmv_pkg.sv
// Shared constants and types for the CSR sparse matrix-vector core.
package csrmv_pkg;

    localparam int CMD_W          = 2;
    localparam int INDEX_W        = 12;
    localparam int VALUE_W        = 16;
    localparam int PROD_W         = 2 * VALUE_W;
    localparam int SUM_W          = 48;
    localparam int ROW_NUM_W      = 16;

    localparam int VECTOR_DEPTH_DEF = 4096;
    localparam int MAX_ROWS_DEF     = 65536;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_EMPTY   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

endpackage

FILE: rtl/csr_sparse_matvec_core.sv
// Sparse matrix times dense vector core: vector memory, multiply and row accumulator.
// The beat that ends a row goes through stage 1 and stage 2 into the output register.
// Throughput: one beat per cycle while no finished row waits on the output register;
// the vector memory read port and the row sum multiply-accumulate loop set that rate.
// Reset clears the pipeline, the output register and the row sum, row counter and clip
// flag; the vector memory holds no reset value and must be loaded before it is read.
module csr_sparse_matvec_core #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter int MAX_ROWS     = csrmv_pkg::MAX_ROWS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [csrmv_pkg::CMD_W-1:0]            command,
    input  logic [csrmv_pkg::INDEX_W-1:0]          index,
    input  logic signed [csrmv_pkg::VALUE_W-1:0]   value,
    input  logic                                   row_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [csrmv_pkg::ROW_NUM_W-1:0]        row_number,
    output logic signed [csrmv_pkg::SUM_W-1:0]     dot_product,
    output logic                                   saturated
);
    import csrmv_pkg::*;

    // Address width of the vector memory, and a common width that holds both the
    // incoming column index and a full memory address.
    localparam int ADDR_W    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    // The dense vector lives in a single-port synchronous memory. A load writes it
    // at the accept edge; a nonzero reads it at its own accept edge, so a load that
    // immediately precedes a nonzero to the same column is always seen.
    logic [VALUE_W-1:0] vec_mem [VECTOR_DEPTH];

    cmd_t                     in_cmd;
    logic [IDX_EXT_W-1:0]     index_ext;
    logic [ADDR_W-1:0]        mem_addr;
    logic                     in_range;
    logic                     accept;

    // Stage 1: accepted beat plus the registered memory read data.
    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic                     s1_row_end_reg;
    logic                     s1_in_range_reg;
    logic [VALUE_W-1:0]       rd_data_reg;

    // Stage 2: registered product, applied to the row accumulator.
    logic                     s2_valid_reg;
    cmd_t                     s2_cmd_reg;
    logic                     s2_row_end_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    // Row state.
    logic signed [SUM_W-1:0]  row_sum_reg;
    logic [ROW_W-1:0]         row_cnt_reg;
    logic                     sum_clip_reg;

    // Output register.
    logic                     out_valid_reg;
    logic [ROW_NUM_W-1:0]     row_number_reg;
    logic signed [SUM_W-1:0]  dot_reg;
    logic                     sat_reg;

    logic signed [VALUE_W-1:0] s1_elem;
    logic signed [PROD_W-1:0]  s1_prod;
    logic signed [SUM_W:0]     sum_wide;
    logic                      sum_ovf;
    logic signed [SUM_W-1:0]   sum_sat;
    logic                      s2_emit;
    logic                      s2_hold;
    logic                      s2_go;
    logic                      s1_hold;
    logic [ROW_W-1:0]          row_cnt_inc;

    assign in_cmd    = cmd_t'(command);
    assign index_ext = IDX_EXT_W'(index);
    assign mem_addr  = index_ext[ADDR_W-1:0];
    assign in_range  = (32'(index) < 32'(VECTOR_DEPTH));

    // Only the output register can stall the pipe, and only a stage 2 beat that
    // finishes a row is held by it. Everything behind keeps moving into bubbles.
    assign s2_emit  = s2_valid_reg &&
                      ((s2_cmd_reg == CMD_EMPTY) ||
                       ((s2_cmd_reg == CMD_NONZERO) && s2_row_end_reg));
    assign s2_hold  = s2_emit && out_valid_reg && !out_ready;
    assign s2_go    = s2_valid_reg && !s2_hold;
    assign s1_hold  = s1_valid_reg && s2_hold;
    assign in_ready = !s1_hold;
    assign accept   = in_valid && in_ready;

    // An index past the vector reads as zero.
    assign s1_elem = s1_in_range_reg ? $signed(rd_data_reg) : '0;
    assign s1_prod = s1_elem * s1_value_reg;

    // 49-bit sum; the two top bits differing means the 48-bit range was left.
    assign sum_wide = {row_sum_reg[SUM_W-1], row_sum_reg} + (SUM_W+1)'(s2_prod_reg);
    assign sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    assign sum_sat  = !sum_ovf ? sum_wide[SUM_W-1:0] :
                      (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX);

    assign row_cnt_inc = (row_cnt_reg == ROW_LAST) ? '0 : row_cnt_reg + 1'b1;

    // Vector memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (accept && (in_cmd == CMD_LOAD) && in_range)
        begin
            vec_mem[mem_addr] <= value;
        end
        if (accept && (in_cmd == CMD_NONZERO))
        begin
            rd_data_reg <= vec_mem[mem_addr];
        end
    end

    // Stage 1 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_hold)
        begin
            s1_valid_reg <= accept && (in_cmd != CMD_NOP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= in_cmd;
            s1_value_reg    <= value;
            s1_row_end_reg  <= row_end;
            s1_in_range_reg <= in_range;
        end
    end

    // Stage 2 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_hold)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s2_hold)
        begin
            s2_cmd_reg     <= s1_cmd_reg;
            s2_row_end_reg <= s1_row_end_reg;
            s2_prod_reg    <= s1_prod;
        end
    end

    // Row accumulator. A load restarts the product; a finished row clears the sum
    // and the clip flag and advances the row number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg  <= '0;
            row_cnt_reg  <= '0;
            sum_clip_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            case (s2_cmd_reg)
                CMD_LOAD:
                begin
                    row_sum_reg  <= '0;
                    row_cnt_reg  <= '0;
                    sum_clip_reg <= 1'b0;
                end
                CMD_NONZERO:
                begin
                    if (s2_row_end_reg)
                    begin
                        row_sum_reg  <= '0;
                        sum_clip_reg <= 1'b0;
                        row_cnt_reg  <= row_cnt_inc;
                    end
                    else
                    begin
                        row_sum_reg  <= sum_sat;
                        sum_clip_reg <= sum_clip_reg | sum_ovf;
                    end
                end
                CMD_EMPTY:
                begin
                    row_sum_reg  <= '0;
                    sum_clip_reg <= 1'b0;
                    row_cnt_reg  <= row_cnt_inc;
                end
                default:
                begin
                    row_sum_reg <= row_sum_reg;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go && s2_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_emit)
        begin
            row_number_reg <= ROW_NUM_W'(row_cnt_reg);
            if (s2_cmd_reg == CMD_NONZERO)
            begin
                dot_reg <= sum_sat;
                sat_reg <= sum_clip_reg | sum_ovf;
            end
            else
            begin
                dot_reg <= row_sum_reg;
                sat_reg <= sum_clip_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_number  = row_number_reg;
    assign dot_product = dot_reg;
    assign saturated   = sat_reg;

`ifndef SYNTHESIS
    // A held stage 2 beat must back-pressure the input when stage 1 is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_hold) |-> !in_ready)
        else $error("input accepted while the pipe is full and stalled");

    // Read data of a stalled nonzero must not be disturbed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hold) |=> $stable(rd_data_reg))
        else $error("memory read data changed under a stalled beat");

    // A load restarts the row state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && (s2_cmd_reg == CMD_LOAD)) |=>
        ((row_sum_reg == '0) && (row_cnt_reg == '0) && !sum_clip_reg))
        else $error("row state not cleared by a vector load");

    // Each emitted row advances the row counter by one, wrapping at the end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s2_emit) |=> (row_cnt_reg == $past(row_cnt_inc)))
        else $error("row counter did not advance on an emitted row");

    // A new result is only loaded once the previous one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s2_emit) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

FILE: sim/csr_sparse_matvec_core_tb.sv
// Self-checking testbench for the CSR sparse matrix-vector core.
`timescale 1ns / 100ps

module csr_sparse_matvec_core_tb;

    import csrmv_pkg::*;

    // A row result goes through stage 1, stage 2 and the output register, so a
    // short tail after the last expected row is enough to catch stray results.
    localparam int DRAIN_CYCLES   = 16;
    // Cycles without any beat on either side before the run is declared hung.
    // The longest sender gap and the longest output stall are both far below this.
    localparam int WATCHDOG_LIMIT = 1000;
    // Random beats that do real work (loads, nonzeros and empty rows).
    localparam int RANDOM_BEATS   = 1795;

    typedef struct packed {
        logic [ROW_NUM_W-1:0]      row;
        logic signed [SUM_W-1:0]   dot;
        logic                      sat;
    } row_result_t;

    // One line of the directed plan. A line with a count above one sends the
    // same beat back to back; a typed result applies to the last of those beats.
    typedef struct {
        cmd_t                      cmd;
        logic [INDEX_W-1:0]        col;
        logic [VALUE_W-1:0]        val;
        logic                      last;
        int unsigned               count;
        bit                        typed;
        row_result_t               want;
    } stim_row_t;

    localparam row_result_t NO_RESULT = '0;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [CMD_W-1:0]              command;
    logic [INDEX_W-1:0]            index;
    logic signed [VALUE_W-1:0]     value;
    logic                          row_end;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ROW_NUM_W-1:0]          row_number;
    logic signed [SUM_W-1:0]       dot_product;
    logic                          saturated;

    // Shadow copy of the core's state, kept in step with accepted beats.
    logic signed [VALUE_W-1:0]     vec_mem [VECTOR_DEPTH_DEF];
    logic signed [SUM_W-1:0]       acc_sum = '0;
    logic [ROW_NUM_W-1:0]          row_cnt = '0;
    logic                          acc_clipped = 1'b0;

    // Vector entries that have been loaded; nonzeros only ever use these columns.
    bit                            col_written [VECTOR_DEPTH_DEF];
    logic [INDEX_W-1:0]            loaded_cols [$];

    row_result_t                   expected_rows [$];
    row_result_t                   oldest_row;
    stim_row_t                     plan [$];

    int                            mismatch_count = 0;
    int                            useful_beats = 0;
    int                            idle_cycles = 0;
    bit                            gaps_off = 1'b0;

    // Output side idling: stall_left counts the cycles still to hold ready low,
    // and steady_ready marks stretches in which the receiver never stalls.
    int                            stall_left = 0;
    bit                            steady_ready = 1'b0;

    always #4 clk = ~clk;

    csr_sparse_matvec_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .index       (index),
        .value       (value),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_number  (row_number),
        .dot_product (dot_product),
        .saturated   (saturated)
    );

    // Advances the shadow state by one accepted beat. Returns 1 when the beat
    // finishes a row, with that row's number, sum and clip flag in res.
    function automatic bit predict_beat(input cmd_t c, input logic [INDEX_W-1:0] col,
                                        input logic signed [VALUE_W-1:0] val,
                                        input logic last, output row_result_t res);
        longint sum;
        longint elem;
        bit emits;
        emits = 1'b0;
        res = NO_RESULT;
        case (c)
            CMD_LOAD:
            begin
                // A load always restarts the product, even for an old index.
                vec_mem[col] = val;
                acc_sum = '0;
                row_cnt = '0;
                acc_clipped = 1'b0;
            end
            CMD_NONZERO:
            begin
                elem = vec_mem[col];
                sum = longint'(acc_sum) + elem * longint'(val);
                if (sum > longint'(SUM_MAX))
                begin
                    sum = longint'(SUM_MAX);
                    acc_clipped = 1'b1;
                end
                else if (sum < longint'(SUM_MIN))
                begin
                    sum = longint'(SUM_MIN);
                    acc_clipped = 1'b1;
                end
                acc_sum = sum[SUM_W-1:0];
                emits = last;
            end
            CMD_EMPTY:
            begin
                // Any partial sum still pending goes out with this row.
                emits = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (emits)
        begin
            res.row = row_cnt;
            res.dot = acc_sum;
            res.sat = acc_clipped;
            acc_sum = '0;
            acc_clipped = 1'b0;
            // The row counter is as wide as MAX_ROWS needs, so it wraps by itself.
            row_cnt = row_cnt + 1'b1;
        end
        return emits;
    endfunction

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int sender_gap();
        int roll;
        if (gaps_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Q4.12 values with the extremes, zero, minus one lsb and one point zero
    // coming up far more often than a flat draw would give them.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_column();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    // Drives one beat after an optional gap and waits for it to be taken. The
    // expected row, if the beat ends one, is queued at the accepting edge; a
    // typed result from the directed plan stands in for the predicted one.
    task automatic send_beat(input cmd_t c, input logic [INDEX_W-1:0] col,
                             input logic [VALUE_W-1:0] val, input logic last,
                             input int gap, input bit typed, input row_result_t want);
        row_result_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        index    <= col;
        value    <= val;
        row_end  <= last;
        do @(posedge clk); while (!in_ready);
        if (predict_beat(c, col, val, last, predicted))
            expected_rows.push_back(typed ? want : predicted);
        if (c == CMD_LOAD && !col_written[col])
        begin
            col_written[col] = 1'b1;
            loaded_cols.push_back(col);
        end
        if (c != CMD_NOP)
            useful_beats++;
    endtask

    // Receiver: stalls of random length, with stretches where it never stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 399) == 0)
            steady_ready <= !steady_ready;
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady_ready && $urandom_range(0, 99) < 15)
        begin
            out_ready  <= 1'b0;
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                        : $urandom_range(7, 39);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result checker: every row beat must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected row result: row %0d sum %0d sat %0b",
                             row_number, dot_product, saturated);
                mismatch_count++;
            end
            else
            begin
                oldest_row = expected_rows.pop_front();
                if (row_number !== oldest_row.row || dot_product !== oldest_row.dot ||
                    saturated !== oldest_row.sat)
                begin
                    if (mismatch_count < 10)
                        $display("row mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 oldest_row.row, oldest_row.dot, oldest_row.sat,
                                 row_number, dot_product, saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: the run is hung if neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int          random_goal;
        int          n_loads;
        int          n_rows;
        int          n_nz;
        bit          pause_next;
        cmd_t        kind;
        logic [INDEX_W-1:0] col;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_LOAD;
        index    = '0;
        value    = '0;
        row_end  = 1'b0;

        // Directed plan. Expected rows are typed in where they are plain to see;
        // the rest come from the shadow model.
        // Vector extremes, plus row_end on a load, which must be ignored.
        plan.push_back('{CMD_LOAD, 12'd0, 16'h8000, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_LOAD, 12'd4095, 16'h7FFF, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_LOAD, 12'd1, 16'h1000, 1'b1, 1, 1'b0, NO_RESULT});
        // An empty row right after loading is row zero with a zero sum.
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 1, 1'b1,
                         '{16'd0, 48'sd0, 1'b0}});
        // One times one in Q4.12 gives one in Q24.24.
        plan.push_back('{CMD_NONZERO, 12'd1, 16'h1000, 1'b1, 1, 1'b1,
                         '{16'd1, 48'sh1000000, 1'b0}});
        // Largest positive product followed by largest negative one.
        plan.push_back('{CMD_NONZERO, 12'd0, 16'h8000, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_NONZERO, 12'd4095, 16'h8000, 1'b1, 1, 1'b0, NO_RESULT});
        // Empty row carrying junk fields and a row_end that means nothing here.
        plan.push_back('{CMD_EMPTY, 12'd4095, 16'hFFFF, 1'b1, 1, 1'b1,
                         '{16'd3, 48'sd0, 1'b0}});
        // The spare command code must leave no trace.
        plan.push_back('{CMD_NOP, 12'd4095, 16'hFFFF, 1'b1, 1, 1'b0, NO_RESULT});
        // A run of the largest positive product, a step back with a negative
        // one, and a zero product that closes the row.
        plan.push_back('{CMD_NONZERO, 12'd0, 16'h8000, 1'b0, 8, 1'b0, NO_RESULT});
        plan.push_back('{CMD_NONZERO, 12'd4095, 16'h8000, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_NONZERO, 12'd1, 16'h0000, 1'b1, 1, 1'b0, NO_RESULT});
        // A run of large negative products left pending; an empty row closes
        // the partial sum, which must come out with it.
        plan.push_back('{CMD_NONZERO, 12'd0, 16'h7FFF, 1'b0, 8, 1'b0, NO_RESULT});
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 1, 1'b0, NO_RESULT});
        // The flag and sum were cleared by that row.
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 1, 1'b1,
                         '{16'd6, 48'sd0, 1'b0}});
        // A stretch of empty rows back to back.
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 20, 1'b0, NO_RESULT});
        // A load restarts the row numbering.
        plan.push_back('{CMD_LOAD, 12'd5, 16'h2000, 1'b1, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 1, 1'b1,
                         '{16'd0, 48'sd0, 1'b0}});
        plan.push_back('{CMD_NONZERO, 12'd4095, 16'h8000, 1'b1, 1, 1'b0, NO_RESULT});
        // A load in the middle of a row throws the partial sum away.
        plan.push_back('{CMD_NONZERO, 12'd1, 16'h1000, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_LOAD, 12'd3, 16'h0001, 1'b0, 1, 1'b0, NO_RESULT});
        plan.push_back('{CMD_EMPTY, 12'd0, 16'h0000, 1'b0, 1, 1'b1,
                         '{16'd0, 48'sd0, 1'b0}});
        plan.push_back('{CMD_NONZERO, 12'd0, 16'hFFFF, 1'b1, 1, 1'b0, NO_RESULT});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Long runs go back to back so the run stays short; the first beat of
        // each plan line may still see a gap.
        foreach (plan[r])
        begin
            for (int unsigned k = 0; k < plan[r].count; k++)
                send_beat(plan[r].cmd, plan[r].col, plan[r].val, plan[r].last,
                          (k == 0) ? sender_gap() : 0,
                          plan[r].typed && k == plan[r].count - 1, plan[r].want);
        end

        // Random part: mostly well-formed products (a few loads, then whole
        // rows over loaded columns), mixed with short bursts of stray beats.
        random_goal = useful_beats + RANDOM_BEATS;
        pause_next = 1'b1;
        while (useful_beats < random_goal)
        begin
            gaps_off = ($urandom_range(0, 4) == 0);
            if (pause_next)
            begin
                // Hold off until every row already ended has come back.
                in_valid <= 1'b0;
                do @(posedge clk); while (expected_rows.size() != 0);
            end
            pause_next = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                n_loads = $urandom_range(1, 12);
                repeat (n_loads)
                begin
                    col = $urandom_range(0, 1) ? 12'($urandom) : pick_column();
                    send_beat(CMD_LOAD, col, pick_value(), 1'($urandom), sender_gap(),
                              1'b0, NO_RESULT);
                end
                n_rows = $urandom_range(1, 8);
                repeat (n_rows)
                begin
                    n_nz = $urandom_range(0, 6);
                    if (n_nz == 0)
                        send_beat(CMD_EMPTY, 12'($urandom), pick_value(), 1'($urandom),
                                  sender_gap(), 1'b0, NO_RESULT);
                    else
                        for (int k = 0; k < n_nz; k++)
                            send_beat(CMD_NONZERO, pick_column(), pick_value(),
                                      k == n_nz - 1, sender_gap(), 1'b0, NO_RESULT);
                end
            end
            else
            begin
                // Stray beats: any command, row_end anywhere, loads mid-row and
                // empty rows on top of partial sums.
                repeat ($urandom_range(1, 4))
                begin
                    kind = cmd_t'($urandom_range(0, 3));
                    col = (kind == CMD_NONZERO) ? pick_column() : 12'($urandom);
                    send_beat(kind, col, pick_value(), 1'($urandom), sender_gap(),
                              1'b0, NO_RESULT);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
